>>> src/hit_or_miss_3x3_stream_top_defines.svh
// Assertion macros for the 3x3 hit-or-miss stream block.
// Both expect clk_i in scope; HOM3_ASSERT also expects rst_ni.
`ifndef HIT_OR_MISS_3X3_STREAM_TOP_DEFINES_SVH
`define HIT_OR_MISS_3X3_STREAM_TOP_DEFINES_SVH
`ifndef SYNTH
// Checked on every rising edge outside reset.
`define HOM3_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hom3 assertion failed");
// Checked on every rising edge, reset included.
`define HOM3_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("hom3 assertion failed");
`else
`define HOM3_ASSERT(label, prop)
`define HOM3_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/hom3_pkg.sv
package hom3_pkg;

  // Frame size limits and derived widths.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WDIM_W      = COL_W + 1;
  localparam int HDIM_W      = ROW_W + 1;
  localparam int MIN_DIM     = 3;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Port widths fixed by the interface.
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_W      = 3;
  localparam int PIX_W       = 8;
  localparam int OUT_COORD_W = 10;

  // Queue between classification and output.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [PIX_W-1:0] PIX_FULL = '1;
  localparam logic [PIX_W-1:0] PIX_ZERO = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK_SELECT  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_index_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET4    = 3'd0,
    MODE_SET8    = 3'd1,
    MODE_SINGLE0 = 3'd2,
    MODE_SINGLE1 = 3'd3,
    MODE_SINGLE2 = 3'd4,
    MODE_SINGLE3 = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_FULL  = 2'd1,
    CLS_OTHER = 2'd2
  } class_e;

  // Masks as two 9-bit vectors; bit (row * 3 + col) of the window.
  // The first vector asks for full pixels, the second for zero pixels.
  localparam logic [8:0] FOUR_FULL [4] = '{
    9'b001_001_001, 9'b000_000_111, 9'b100_100_100, 9'b111_000_000
  };
  localparam logic [8:0] FOUR_ZERO [4] = '{
    9'b000_010_000, 9'b000_010_000, 9'b000_010_000, 9'b000_010_000
  };
  localparam logic [8:0] EIGHT_FULL [8] = '{
    9'b111_010_000, 9'b011_011_000, 9'b001_011_001, 9'b000_011_011,
    9'b000_010_111, 9'b000_110_110, 9'b100_110_100, 9'b110_110_000
  };
  localparam logic [8:0] EIGHT_ZERO [8] = '{
    9'b000_000_111, 9'b000_100_110, 9'b100_100_100, 9'b110_100_000,
    9'b111_000_000, 9'b011_001_000, 9'b001_001_001, 9'b000_001_011
  };

  // One queue entry: the interior result and the border result, each if any.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              has_inner;
    logic              inner_hit;
    logic              has_border;
    logic [PIX_W-1:0]  border_pix;
  } item_t;

  function automatic class_e classify(input logic [PIX_W-1:0] pix);
    class_e cls;
    if (pix == PIX_ZERO) begin
      cls = CLS_ZERO;
    end else if (pix == PIX_FULL) begin
      cls = CLS_FULL;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  function automatic logic mask_match(input logic [8:0] is_full, input logic [8:0] is_zero,
                                      input logic [8:0] need_full,
                                      input logic [8:0] need_zero);
    return ((need_full & ~is_full) | (need_zero & ~is_zero)) == 9'd0;
  endfunction

  function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'(MIN_DIM)) begin
      x = 32'(MIN_DIM);
    end else if (x > 32'(MAX_WIDTH)) begin
      x = 32'(MAX_WIDTH);
    end
    return WDIM_W'(x);
  endfunction

  function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'(MIN_DIM)) begin
      x = 32'(MIN_DIM);
    end else if (x > 32'(MAX_HEIGHT)) begin
      x = 32'(MAX_HEIGHT);
    end
    return HDIM_W'(x);
  endfunction

endpackage

>>> src/hom3_front.sv
module hom3_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hom3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hom3_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hom3_pkg::PIX_W-1:0]   pixel_value_i,
  output logic                         push_o,
  output hom3_pkg::item_t              item_o,
  input  logic                         full_i
);

  logic [hom3_pkg::MODE_W-1:0] mask_select_q;
  logic [hom3_pkg::WDIM_W-1:0] width_q;
  logic [hom3_pkg::HDIM_W-1:0] height_q;
  logic [hom3_pkg::COL_W-1:0]  col_q, col_d;
  logic [hom3_pkg::ROW_W-1:0]  row_q, row_d;

  logic                        s2_valid_q, s2_valid_d;
  logic [hom3_pkg::COL_W-1:0]  s2_col_q;
  logic [hom3_pkg::ROW_W-1:0]  s2_row_q;
  logic [hom3_pkg::PIX_W-1:0]  s2_pix_q;
  hom3_pkg::class_e            s2_cls_q;
  logic [1:0]                  up_rd_q, mid_rd_q;

  logic [8:0][1:0]             win_q, win_d;
  logic [8:0]                  is_full, is_zero;
  logic [3:0]                  hit4;
  logic [7:0]                  hit8;
  logic                        hit, set_mode, has_inner, has_border, need_push;
  logic [hom3_pkg::PIX_W-1:0]  border_pix;
  logic                        accept, s2_adv;

  logic [1:0] upper_mem  [hom3_pkg::MAX_WIDTH];
  logic [1:0] middle_mem [hom3_pkg::MAX_WIDTH];

  // Handshake between the input port, the second stage and the queue.
  assign need_push  = has_inner | has_border;
  assign s2_adv     = s2_valid_q & (~need_push | ~full_i);
  assign push_o     = s2_valid_q & need_push & ~full_i;
  assign in_stall_o = s2_valid_q & ~s2_adv;
  assign accept     = in_valid_i & ~in_stall_o;

  // Raster position of the next pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ({1'b0, col_q} + hom3_pkg::WDIM_W'(1) >= width_q) begin
        col_d = '0;
        if ({1'b0, row_q} + hom3_pkg::HDIM_W'(1) >= height_q) begin
          row_d = '0;
        end else begin
          row_d = row_q + hom3_pkg::ROW_W'(1);
        end
      end else begin
        col_d = col_q + hom3_pkg::COL_W'(1);
      end
    end
  end

  // Configuration registers and position counters; a size write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_select_q <= hom3_pkg::MODE_SET4;
      width_q       <= hom3_pkg::clamp_width(hom3_pkg::CFG_W'(hom3_pkg::RESET_WIDTH));
      height_q      <= hom3_pkg::clamp_height(hom3_pkg::CFG_W'(hom3_pkg::RESET_HEIGHT));
      col_q         <= '0;
      row_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (hom3_pkg::cfg_index_e'(cfg_index_i))
        hom3_pkg::CFG_MASK_SELECT: begin
          mask_select_q <= cfg_wdata_i[hom3_pkg::MODE_W-1:0];
        end
        hom3_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= hom3_pkg::clamp_width(cfg_wdata_i);
          col_q   <= '0;
          row_q   <= '0;
        end
        hom3_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= hom3_pkg::clamp_height(cfg_wdata_i);
          col_q    <= '0;
          row_q    <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: read as a pixel is taken, written back as it leaves the second stage.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
      s2_col_q <= col_q;
      s2_row_q <= row_q;
      s2_pix_q <= pixel_value_i;
      s2_cls_q <= hom3_pkg::classify(pixel_value_i);
    end
    if (s2_adv) begin
      upper_mem[s2_col_q]  <= mid_rd_q;
      middle_mem[s2_col_q] <= s2_cls_q;
    end
  end

  // Second stage occupancy and the 3x3 class window.
  assign s2_valid_d = accept | (s2_valid_q & ~s2_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (s2_adv) begin
        win_q <= win_d;
      end
    end
  end

  // Shift the window one column left and bring in the new column.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = up_rd_q;
    win_d[5] = mid_rd_q;
    win_d[8] = s2_cls_q;
    for (int i = 0; i < 9; i++) begin
      is_full[i] = (win_d[i] == hom3_pkg::CLS_FULL);
      is_zero[i] = (win_d[i] == hom3_pkg::CLS_ZERO);
    end
  end

  // All masks are matched side by side.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit4[k] = hom3_pkg::mask_match(is_full, is_zero,
                                     hom3_pkg::FOUR_FULL[k], hom3_pkg::FOUR_ZERO[k]);
    end
    for (int k = 0; k < 8; k++) begin
      hit8[k] = hom3_pkg::mask_match(is_full, is_zero,
                                     hom3_pkg::EIGHT_FULL[k], hom3_pkg::EIGHT_ZERO[k]);
    end
  end

  // Mode decode; the unused codes behave as the four-mask set.
  always_comb begin
    set_mode = 1'b0;
    unique case (mask_select_q)
      hom3_pkg::MODE_SET8:    hit = |hit8;
      hom3_pkg::MODE_SINGLE0: hit = hit4[0];
      hom3_pkg::MODE_SINGLE1: hit = hit4[1];
      hom3_pkg::MODE_SINGLE2: hit = hit4[2];
      hom3_pkg::MODE_SINGLE3: hit = hit4[3];
      default:                hit = |hit4;
    endcase
    unique case (mask_select_q) inside
      hom3_pkg::MODE_SINGLE0, hom3_pkg::MODE_SINGLE1,
      hom3_pkg::MODE_SINGLE2, hom3_pkg::MODE_SINGLE3: set_mode = 1'b0;
      default:                                        set_mode = 1'b1;
    endcase
  end

  // The new pixel completes the window of the pixel up and to the left.
  always_comb begin
    has_inner = (s2_col_q >= hom3_pkg::COL_W'(2))
              & ({1'b0, s2_col_q} + hom3_pkg::WDIM_W'(1) <= width_q)
              & (s2_row_q >= hom3_pkg::ROW_W'(2))
              & ({1'b0, s2_row_q} + hom3_pkg::HDIM_W'(1) <= height_q);
    has_border = (s2_col_q == '0) | (s2_row_q == '0)
               | ({1'b0, s2_col_q} + hom3_pkg::WDIM_W'(1) >= width_q)
               | ({1'b0, s2_row_q} + hom3_pkg::HDIM_W'(1) >= height_q);
    if (!set_mode) begin
      border_pix = s2_pix_q;
    end else if (s2_pix_q == hom3_pkg::PIX_FULL) begin
      border_pix = hom3_pkg::PIX_FULL;
    end else begin
      border_pix = hom3_pkg::PIX_ZERO;
    end
  end

  assign item_o.col        = s2_col_q;
  assign item_o.row        = s2_row_q;
  assign item_o.has_inner  = has_inner;
  assign item_o.inner_hit  = hit;
  assign item_o.has_border = has_border;
  assign item_o.border_pix = border_pix;

endmodule

>>> src/hom3_fifo.sv
module hom3_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hom3_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output hom3_pkg::item_t head_o,
  output logic            empty_o
);

  hom3_pkg::item_t               entries_q [hom3_pkg::FIFO_DEPTH];
  logic [hom3_pkg::FIFO_PTR_W:0] wr_ptr_q, rd_ptr_q;

  // The extra pointer bit tells a full queue from an empty one.
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[hom3_pkg::FIFO_PTR_W] != rd_ptr_q[hom3_pkg::FIFO_PTR_W])
                 & (wr_ptr_q[hom3_pkg::FIFO_PTR_W-1:0] == rd_ptr_q[hom3_pkg::FIFO_PTR_W-1:0]);
  assign head_o  = entries_q[rd_ptr_q[hom3_pkg::FIFO_PTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q[hom3_pkg::FIFO_PTR_W-1:0]] <= item_i;
    end
  end

endmodule

>>> src/hom3_back.sv
module hom3_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hom3_pkg::item_t                   head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hom3_pkg::OUT_COORD_W-1:0]  out_col_o,
  output logic [hom3_pkg::OUT_COORD_W-1:0]  out_row_o,
  output logic [hom3_pkg::PIX_W-1:0]        out_pixel_o,
  output logic                              last_in_run_o
);

  logic                             out_valid_q;
  logic                             phase_q;
  logic [hom3_pkg::OUT_COORD_W-1:0] out_col_q, out_row_q;
  logic [hom3_pkg::PIX_W-1:0]       out_pixel_q;
  logic                             last_q;
  logic                             load, inner_turn, last_part;

  // A result is loaded whenever the output register is free or being taken.
  assign load       = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign inner_turn = head_i.has_inner & ~phase_q;
  assign last_part  = ~inner_turn | ~head_i.has_border;
  assign pop_o      = load & last_part;

  // Control: output occupancy and whether the interior result has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= ~last_part;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: the interior result first, then the border result.
  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= last_part;
      if (inner_turn) begin
        out_col_q   <= hom3_pkg::OUT_COORD_W'(head_i.col - hom3_pkg::COL_W'(1));
        out_row_q   <= hom3_pkg::OUT_COORD_W'(head_i.row - hom3_pkg::ROW_W'(1));
        out_pixel_q <= head_i.inner_hit ? hom3_pkg::PIX_FULL : hom3_pkg::PIX_ZERO;
      end else begin
        out_col_q   <= hom3_pkg::OUT_COORD_W'(head_i.col);
        out_row_q   <= hom3_pkg::OUT_COORD_W'(head_i.row);
        out_pixel_q <= head_i.border_pix;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_col_o     = out_col_q;
  assign out_row_o     = out_row_q;
  assign out_pixel_o   = out_pixel_q;
  assign last_in_run_o = last_q;

endmodule

>>> src/hit_or_miss_3x3_stream_top.sv
// 3x3 hit-or-miss transform on a raster stream of 8-bit pixels. One pixel
// can be taken every cycle; it is classified and windowed in a two-stage
// front end built round two line stores (each with one read and one write
// per cycle), and its results wait in a four-entry queue for the output
// register, which sends one result per cycle unless stalled. A pixel gives
// zero, one or two results (the interior result of the pixel up and to the
// left first, then its own result if it lies on the frame border), and a
// pixel's two results leave one after the other. Input is held off only
// when the queue is full, as under output stalls or along the last row,
// where every pixel from the third column on gives two results. Results
// carry their coordinates; last_in_run_o marks each pixel's final result.
// Line stores are not cleared after reset; their unwritten contents never
// reach a result. Configuration must be written only while the block is
// idle (the block does not enforce this); a size write restarts the frame.
`include "hit_or_miss_3x3_stream_top_defines.svh"

module hit_or_miss_3x3_stream_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hom3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hom3_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hom3_pkg::PIX_W-1:0]        pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hom3_pkg::OUT_COORD_W-1:0]  out_col_o,
  output logic [hom3_pkg::OUT_COORD_W-1:0]  out_row_o,
  output logic [hom3_pkg::PIX_W-1:0]        out_pixel_o,
  output logic                              last_in_run_o
);

  logic            q_push, q_full, q_pop, q_empty;
  hom3_pkg::item_t q_item, q_head;

  // Front end: position, line stores, window and mask matching.
  hom3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .push_o        (q_push),
    .item_o        (q_item),
    .full_i        (q_full)
  );

  // Queue between the two halves.
  hom3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Back end: splits each entry into its results.
  hom3_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .out_pixel_o   (out_pixel_o),
    .last_in_run_o (last_in_run_o)
  );

  // The queue is never written when full nor read when empty.
  `HOM3_ASSERT(a_no_overflow, q_push |-> !q_full)
  `HOM3_ASSERT(a_no_underflow, q_pop |-> !q_empty)
  // A pixel's results leave back to back, with no gap inside a run.
  `HOM3_ASSERT(a_run_unbroken, out_valid_o && !last_in_run_o |=> out_valid_o)
  // Nothing is offered while reset is applied.
  `HOM3_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !out_valid_o)

endmodule
